[sv/satellite_beam_visibility_check_assert.svh]
// Assertion macros for the visibility pipeline
`ifndef SATELLITE_BEAM_VISIBILITY_CHECK_ASSERT_SVH
`define SATELLITE_BEAM_VISIBILITY_CHECK_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SBVC_ASSERT_IMPLY(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error(msg);

// antecedent implies consequent after the delay given by argument n
`define SBVC_ASSERT_DELAY(lbl, a, n, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> ##(n) (c)) \
		else $error(msg);

`endif

[sv/sbvc_pkg.sv]
package sbvc_pkg;

	localparam int COORD_W = 28;
	localparam int VEC_W = COORD_W + 1;
	localparam int PROD_W = 2 * VEC_W;
	localparam int SUMSQ_W = PROD_W;
	localparam int DOT_W = PROD_W + 2;
	localparam int ROOT_W = SUMSQ_W + 1;
	localparam int NORM_W = VEC_W;
	localparam int SQRT_STEPS = NORM_W;
	localparam int DEN_W = 2 * NORM_W;
	localparam int DENN_W = 44;
	localparam int SHIFT_W = $clog2(DEN_W - DENN_W + 1);
	localparam int MAG_W = DOT_W - 1;
	localparam int FRAC_W = 16;
	localparam int Q16_W = FRAC_W + 1;
	localparam int DIV_BITS = 20;
	localparam int REM_W = 64;
	localparam int EARTH_W = NORM_W + FRAC_W;
	// s1..s3, square root steps, s5..s7, divider steps, s9
	localparam int PIPE_LAT = 3 + SQRT_STEPS + 3 + DIV_BITS + 1;

	localparam logic [Q16_W-1:0] COS_NARROW = 17'd63625;
	localparam logic [Q16_W-1:0] COS_WIDE = 17'd61059;
	localparam logic [Q16_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic [2:0] RSN_VISIBLE = 3'd0;
	localparam logic [2:0] RSN_OUTSIDE = 3'd1;
	localparam logic [2:0] RSN_BLOCKED = 3'd2;
	localparam logic [2:0] RSN_CUTOFF = 3'd3;
	localparam logic [2:0] RSN_DEGEN = 3'd4;

	typedef struct packed {
		logic signed [COORD_W-1:0] sat_x;
		logic signed [COORD_W-1:0] sat_y;
		logic signed [COORD_W-1:0] sat_z;
		logic signed [COORD_W-1:0] rec_x;
		logic signed [COORD_W-1:0] rec_y;
		logic signed [COORD_W-1:0] rec_z;
	} item_t;

	typedef struct packed {
		logic visible;
		logic [2:0] reason;
	} result_t;

	typedef struct packed {
		logic [SUMSQ_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sqrt_st_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DIV_BITS-1:0] quot;
	} div_st_t;

	// one digit of the bitwise integer square root
	function automatic sqrt_st_t sqrt_step(input sqrt_st_t st, input int k);
		logic [ROOT_W-1:0] b;
		logic [ROOT_W:0] t;
		sqrt_st_t o;
		b = ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
		t = {1'b0, st.root} + {1'b0, b};
		o = st;
		if ({{(ROOT_W + 1 - SUMSQ_W){1'b0}}, st.rem} >= t) begin
			o.rem = st.rem - t[SUMSQ_W-1:0];
			o.root = (st.root >> 1) + b;
		end else begin
			o.root = st.root >> 1;
		end
		return o;
	endfunction

	// one quotient bit of restoring division
	function automatic div_st_t div_step(input div_st_t st, input logic [DENN_W-1:0] den,
			input int k);
		logic [REM_W-1:0] d;
		div_st_t o;
		d = REM_W'(den) << (DIV_BITS - 1 - k);
		o = st;
		if (st.rem >= d) begin
			o.rem = st.rem - d;
			o.quot[DIV_BITS-1-k] = 1'b1;
		end
		return o;
	endfunction

endpackage

[sv/satellite_beam_visibility_check.sv]
// Satellite beam visibility check. One item per clock: an item is taken whenever start is
// high (busy is never raised) and its verdict appears on result, marked by done for a single
// cycle; the receiver cannot stall, so it must take every done beat. Most of the pipeline is
// the 29-step square root pipeline for the three norms and the 20-step divider pipeline for the
// two cosines. sin_cutoff is written over the cfg channel, which is always ready; write it only
// while no item is in flight.
`include "satellite_beam_visibility_check_assert.svh"

module satellite_beam_visibility_check (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input sbvc_pkg::item_t item,
	output logic done,
	output sbvc_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [sbvc_pkg::Q16_W-1:0] cfg_data
);
	import sbvc_pkg::*;

	// index 0: satellite, 1: receiver, 2: line of sight
	typedef struct packed {
		sqrt_st_t [2:0] n;
		logic signed [DOT_W-1:0] dth;
		logic signed [DOT_W-1:0] dze;
		logic deg;
	} sq_pipe_t;

	// index 0: off-nadir cosine, 1: zenith cosine
	typedef struct packed {
		div_st_t [1:0] d;
		logic [1:0][DENN_W-1:0] den;
		logic [1:0] sat;
		logic [1:0] neg;
		logic earth;
		logic deg;
	} dv_pipe_t;

	function automatic sq_pipe_t sq_stage(input sq_pipe_t x, input int k);
		sq_pipe_t o;
		o = x;
		for (int j = 0; j < 3; j++) begin
			o.n[j] = sqrt_step(x.n[j], k);
		end
		return o;
	endfunction

	function automatic dv_pipe_t dv_stage(input dv_pipe_t x, input int k);
		dv_pipe_t o;
		o = x;
		for (int j = 0; j < 2; j++) begin
			o.d[j] = div_step(x.d[j], x.den[j], k);
		end
		return o;
	endfunction

	function automatic logic [SHIFT_W-1:0] shamt(input logic [DEN_W-1:0] d);
		logic [SHIFT_W-1:0] s;
		s = '0;
		for (int i = DENN_W; i < DEN_W; i++) begin
			if (d[i]) begin
				s = SHIFT_W'(i - DENN_W + 1);
			end
		end
		return s;
	endfunction

	logic [Q16_W-1:0] sin_cutoff_q;

	logic v_s1, v_s2, v_s3, v_s5, v_s6, v_s7, v_s9;
	logic [SQRT_STEPS-1:0] sq_v_s4;
	logic [DIV_BITS-1:0] dv_v_s8;

	logic signed [VEC_W-1:0] se [3];
	logic signed [VEC_W-1:0] pe [3];
	logic signed [VEC_W-1:0] s_s1 [3];
	logic signed [VEC_W-1:0] p_s1 [3];
	logic signed [VEC_W-1:0] r_s1 [3];
	logic deg_s1, deg_s2, deg_s3, deg_s5;

	logic signed [PROD_W-1:0] ss_s2 [3];
	logic signed [PROD_W-1:0] pp_s2 [3];
	logic signed [PROD_W-1:0] rr_s2 [3];
	logic signed [PROD_W-1:0] sr_s2 [3];
	logic signed [PROD_W-1:0] pr_s2 [3];

	logic signed [DOT_W-1:0] ss_sum, pp_sum, rr_sum, sr_sum, pr_sum;
	logic [SUMSQ_W-1:0] ss_s3, pp_s3, rr_s3;
	logic signed [DOT_W-1:0] dth_s3, dze_s3;

	sq_pipe_t sq_in;
	sq_pipe_t sq_nx [SQRT_STEPS];
	sq_pipe_t sq_s4 [SQRT_STEPS];
	sq_pipe_t sq_last;

	logic [DEN_W-1:0] den_s5 [2];
	logic signed [DOT_W-1:0] dot_s5 [2];
	logic [EARTH_W-1:0] earth_r_s5;
	logic [NORM_W-1:0] nr_s5;

	logic [SHIFT_W-1:0] sh [2];
	logic [MAG_W-1:0] mag [2];
	logic [DENN_W-1:0] den_s6 [2];
	logic [MAG_W-1:0] mag_s6 [2];
	logic [1:0] neg_s6;
	logic earth_s6, deg_s6;

	dv_pipe_t dv_s7;
	dv_pipe_t dv_nx [DIV_BITS];
	dv_pipe_t dv_s8 [DIV_BITS];
	dv_pipe_t dv_last;

	logic [Q16_W-1:0] q [2];
	result_t res;
	result_t res_s9;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_cutoff_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			sq_v_s4 <= '0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			dv_v_s8 <= '0;
			v_s9 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sin_cutoff_q <= cfg_data;
			end
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			sq_v_s4 <= {sq_v_s4[SQRT_STEPS-2:0], v_s3};
			v_s5 <= sq_v_s4[SQRT_STEPS-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			dv_v_s8 <= {dv_v_s8[DIV_BITS-2:0], v_s7};
			v_s9 <= dv_v_s8[DIV_BITS-1];
		end
	end

	// s1: operands and line of sight
	always_comb begin
		se[0] = {item.sat_x[COORD_W-1], item.sat_x};
		se[1] = {item.sat_y[COORD_W-1], item.sat_y};
		se[2] = {item.sat_z[COORD_W-1], item.sat_z};
		pe[0] = {item.rec_x[COORD_W-1], item.rec_x};
		pe[1] = {item.rec_y[COORD_W-1], item.rec_y};
		pe[2] = {item.rec_z[COORD_W-1], item.rec_z};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s1[i] <= se[i];
			p_s1[i] <= pe[i];
			r_s1[i] <= pe[i] - se[i];
		end
		deg_s1 <= (se[0] == '0 && se[1] == '0 && se[2] == '0)
			|| (pe[0] == '0 && pe[1] == '0 && pe[2] == '0)
			|| (se[0] == pe[0] && se[1] == pe[1] && se[2] == pe[2]);
	end

	// s2: products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ss_s2[i] <= s_s1[i] * s_s1[i];
			pp_s2[i] <= p_s1[i] * p_s1[i];
			rr_s2[i] <= r_s1[i] * r_s1[i];
			sr_s2[i] <= s_s1[i] * r_s1[i];
			pr_s2[i] <= p_s1[i] * r_s1[i];
		end
		deg_s2 <= deg_s1;
	end

	// s3: sums of squares and the two dot products, both negated
	always_comb begin
		ss_sum = DOT_W'(ss_s2[0]) + DOT_W'(ss_s2[1]) + DOT_W'(ss_s2[2]);
		pp_sum = DOT_W'(pp_s2[0]) + DOT_W'(pp_s2[1]) + DOT_W'(pp_s2[2]);
		rr_sum = DOT_W'(rr_s2[0]) + DOT_W'(rr_s2[1]) + DOT_W'(rr_s2[2]);
		sr_sum = DOT_W'(sr_s2[0]) + DOT_W'(sr_s2[1]) + DOT_W'(sr_s2[2]);
		pr_sum = DOT_W'(pr_s2[0]) + DOT_W'(pr_s2[1]) + DOT_W'(pr_s2[2]);
	end

	always_ff @(posedge clk) begin
		ss_s3 <= ss_sum[SUMSQ_W-1:0];
		pp_s3 <= pp_sum[SUMSQ_W-1:0];
		rr_s3 <= rr_sum[SUMSQ_W-1:0];
		dth_s3 <= -sr_sum;
		dze_s3 <= -pr_sum;
		deg_s3 <= deg_s2;
	end

	// s4: square roots, one digit per stage
	always_comb begin
		sq_in.n[0].rem = ss_s3;
		sq_in.n[0].root = '0;
		sq_in.n[1].rem = pp_s3;
		sq_in.n[1].root = '0;
		sq_in.n[2].rem = rr_s3;
		sq_in.n[2].root = '0;
		sq_in.dth = dth_s3;
		sq_in.dze = dze_s3;
		sq_in.deg = deg_s3;
		sq_nx[0] = sq_stage(sq_in, 0);
		for (int k = 1; k < SQRT_STEPS; k++) begin
			sq_nx[k] = sq_stage(sq_s4[k-1], k);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < SQRT_STEPS; k++) begin
			sq_s4[k] <= sq_nx[k];
		end
	end

	assign sq_last = sq_s4[SQRT_STEPS-1];

	// s5: norm products and the Earth limit
	always_ff @(posedge clk) begin
		den_s5[0] <= DEN_W'(sq_last.n[0].root[NORM_W-1:0])
			* DEN_W'(sq_last.n[2].root[NORM_W-1:0]);
		den_s5[1] <= DEN_W'(sq_last.n[1].root[NORM_W-1:0])
			* DEN_W'(sq_last.n[2].root[NORM_W-1:0]);
		earth_r_s5 <= EARTH_W'(sq_last.n[0].root[NORM_W-1:0]) * EARTH_W'(COS_NARROW);
		nr_s5 <= sq_last.n[2].root[NORM_W-1:0];
		dot_s5[0] <= sq_last.dth;
		dot_s5[1] <= sq_last.dze;
		deg_s5 <= sq_last.deg;
	end

	// s6: scale denominator below 2^44, dividend with it
	always_comb begin
		for (int j = 0; j < 2; j++) begin
			sh[j] = shamt(den_s5[j]);
			mag[j] = dot_s5[j][DOT_W-1] ? MAG_W'(-dot_s5[j]) : MAG_W'(dot_s5[j]);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 2; j++) begin
			den_s6[j] <= DENN_W'(den_s5[j] >> sh[j]);
			mag_s6[j] <= mag[j] >> sh[j];
			neg_s6[j] <= dot_s5[j][DOT_W-1];
		end
		earth_s6 <= {nr_s5, {FRAC_W{1'b0}}} < earth_r_s5;
		deg_s6 <= deg_s5;
	end

	// s7: divider set-up; quotients of 2^20 or more saturate
	always_ff @(posedge clk) begin
		for (int j = 0; j < 2; j++) begin
			dv_s7.d[j].rem <= REM_W'(mag_s6[j]) << FRAC_W;
			dv_s7.d[j].quot <= '0;
			dv_s7.den[j] <= den_s6[j];
			dv_s7.sat[j] <= mag_s6[j]
				>= MAG_W'({den_s6[j], {(DIV_BITS - FRAC_W){1'b0}}});
		end
		dv_s7.neg <= neg_s6;
		dv_s7.earth <= earth_s6;
		dv_s7.deg <= deg_s6;
	end

	// s8: division, one quotient bit per stage
	always_comb begin
		dv_nx[0] = dv_stage(dv_s7, 0);
		for (int k = 1; k < DIV_BITS; k++) begin
			dv_nx[k] = dv_stage(dv_s8[k-1], k);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_BITS; k++) begin
			dv_s8[k] <= dv_nx[k];
		end
	end

	assign dv_last = dv_s8[DIV_BITS-1];

	// s9: verdict
	always_comb begin
		for (int j = 0; j < 2; j++) begin
			if (dv_last.sat[j] || dv_last.d[j].quot > DIV_BITS'(ONE_Q16)) begin
				q[j] = ONE_Q16;
			end else begin
				q[j] = dv_last.d[j].quot[Q16_W-1:0];
			end
		end
		res.visible = 1'b0;
		if (dv_last.deg) begin
			res.reason = RSN_DEGEN;
		end else begin
			if (!dv_last.neg[0] && q[0] >= COS_WIDE && q[0] <= COS_NARROW) begin
				res.reason = RSN_VISIBLE;
			end else if (!dv_last.neg[0] && q[0] > COS_NARROW) begin
				res.reason = dv_last.earth ? RSN_VISIBLE : RSN_BLOCKED;
			end else begin
				res.reason = RSN_OUTSIDE;
			end
			if (res.reason == RSN_VISIBLE) begin
				if (!dv_last.neg[1] && q[1] > sin_cutoff_q) begin
					res.visible = 1'b1;
				end else begin
					res.reason = RSN_CUTOFF;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s9 <= res;
	end

	assign done = v_s9;
	assign result = res_s9;

	`SBVC_ASSERT_DELAY(a_item_done, start && !busy, PIPE_LAT, done, "accepted item gave no result")
	`SBVC_ASSERT_DELAY(a_no_ghost, !(start && !busy), PIPE_LAT, !done, "result without item")
	`SBVC_ASSERT_IMPLY(a_vis_reason, done, result.visible == (result.reason == RSN_VISIBLE),
		"visible flag disagrees with reason")

endmodule
